// ===== rtl/gsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsfp_pkg
// Types and constants shared by the gas sensor frame parser.
// ----------------------------------------------------------------------------
package gsfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 4;

    // frame byte constants
    localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFF;
    localparam logic [BYTE_W-1:0] GAS_CODE      = 8'h17;
    localparam logic [BYTE_W-1:0] UNIT_CODE     = 8'h04;
    localparam logic [BYTE_W-1:0] DECIMALS_CODE = 8'h00;

    // frame position codes, next expected byte
    localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
    localparam logic [POS_W-1:0] POS_GAS      = 4'd1;
    localparam logic [POS_W-1:0] POS_UNIT     = 4'd2;
    localparam logic [POS_W-1:0] POS_DEC      = 4'd3;
    localparam logic [POS_W-1:0] POS_CONC_HI  = 4'd4;
    localparam logic [POS_W-1:0] POS_CONC_LO  = 4'd5;
    localparam logic [POS_W-1:0] POS_RANGE_HI = 4'd6;
    localparam logic [POS_W-1:0] POS_RANGE_LO = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd8;

    // result status codes
    localparam logic STATUS_READING  = 1'b0;
    localparam logic STATUS_CHECKSUM = 1'b1;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] rx_byte;
    } t_step;

    typedef struct packed {
        logic              vld;
        logic              status;
        logic [WORD_W-1:0] concentration;
        logic [WORD_W-1:0] full_range;
    } t_result;

endpackage

// ===== rtl/gsfp_if.sv =====
// ----------------------------------------------------------------------------
// gsfp stream interfaces
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface gsfp_byte_if;
    import gsfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gsfp_result_if;
    import gsfp_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [WORD_W-1:0] concentration;
    logic [WORD_W-1:0] full_range;

    modport source (output valid, output status, output concentration,
                    output full_range, input ready);
    modport sink (input valid, input status, input concentration,
                  input full_range, output ready);
endinterface

// ===== rtl/gsfp_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// gsfp_frame_fsm
// Frame position tracking, field assembly, checksum test and change filter.
// One byte is consumed per step; the result is produced in the same cycle.
// ----------------------------------------------------------------------------
module gsfp_frame_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gsfp_pkg::t_step   i_step,
    output gsfp_pkg::t_result o_res
);
    import gsfp_pkg::*;

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [BYTE_W-1:0] r_sum,  n_sum;
    logic [WORD_W-1:0] r_val,  n_val;
    logic [WORD_W-1:0] r_rng,  n_rng;
    logic [WORD_W-1:0] r_last, n_last;

    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] want;
    logic              hdr_ok;

    assign b    = i_step.rx_byte;
    assign want = BYTE_W'(8'd0 - r_sum);

    always_comb begin
        unique case (r_pos)
            POS_GAS:  hdr_ok = (b == GAS_CODE);
            POS_UNIT: hdr_ok = (b == UNIT_CODE);
            POS_DEC:  hdr_ok = (b == DECIMALS_CODE);
            default:  hdr_ok = 1'b1;
        endcase
    end

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_val  = r_val;
        n_rng  = r_rng;
        n_last = r_last;
        o_res  = '0;
        o_res.concentration = r_val;
        o_res.full_range    = r_rng;
        if (i_step.vld) begin
            unique case (r_pos)
                POS_GAS, POS_UNIT, POS_DEC: begin
                    if (hdr_ok) begin
                        n_sum = r_sum + b;
                        n_pos = r_pos + 4'd1;
                    end else begin
                        n_pos = POS_HUNT;
                    end
                end
                POS_CONC_HI, POS_CONC_LO, POS_RANGE_HI, POS_RANGE_LO: begin
                    unique case (r_pos)
                        POS_CONC_HI:  n_val = {b, 8'h00};
                        POS_CONC_LO:  n_val = {r_val[WORD_W-1:BYTE_W], b};
                        POS_RANGE_HI: n_rng = {b, 8'h00};
                        default:      n_rng = {r_rng[WORD_W-1:BYTE_W], b};
                    endcase
                    n_sum = r_sum + b;
                    n_pos = r_pos + 4'd1;
                end
                POS_CHECK: begin
                    n_pos = POS_HUNT;
                    if (want == b) begin
                        if (r_val != r_last) begin
                            o_res.vld    = 1'b1;
                            o_res.status = STATUS_READING;
                            n_last       = r_val;
                        end
                    end else begin
                        o_res.vld    = 1'b1;
                        o_res.status = STATUS_CHECKSUM;
                    end
                end
                default: begin
                    // hunting, also unused position codes
                    if (b == START_BYTE) begin
                        n_sum = '0;
                        n_pos = POS_GAS;
                    end else begin
                        n_pos = POS_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HUNT;
            r_sum  <= '0;
            r_val  <= '0;
            r_rng  <= '0;
            r_last <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_val  <= n_val;
            r_rng  <= n_rng;
            r_last <= n_last;
        end
    end

endmodule

// ===== rtl/gas_sensor_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_frame_parser_top
// Parses 9-byte gas sensor frames from a received UART byte stream.
// ----------------------------------------------------------------------------
// Bytes enter an input register and are parsed from it when the output
// register can advance; a result, when the frame produces one, then lands
// in the output register. One byte is taken every cycle; the only limit is
// the output register: while it holds an untaken result and the sink
// stalls, a byte waits in the input register and input ready drops.
// A result is given for a completed frame whose checksum fails (status 1)
// or whose good concentration differs from the last reported one (status 0,
// initially compared with zero).
module gas_sensor_frame_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gsfp_byte_if.sink     i_rx,
    gsfp_result_if.source o_res
);
    import gsfp_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    logic              r_out_status;
    logic [WORD_W-1:0] r_out_conc;
    logic [WORD_W-1:0] r_out_rng;

    logic    adv;
    t_step   step;
    t_result res;

    assign adv        = !r_out_vld || o_res.ready;
    assign i_rx.ready = !r_in_vld || adv;

    assign step.vld     = r_in_vld && adv;
    assign step.rx_byte = r_in_byte;

    gsfp_frame_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_vld <= i_rx.valid;
            end
            if (adv) begin
                r_out_vld <= res.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (adv && res.vld) begin
            r_out_status <= res.status;
            r_out_conc   <= res.concentration;
            r_out_rng    <= res.full_range;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_out_status;
    assign o_res.concentration = r_out_conc;
    assign o_res.full_range    = r_out_rng;

endmodule

// ===== rtl/gsfp_checker.sv =====
// ----------------------------------------------------------------------------
// gsfp_checker
// Port-level checks for the gas sensor frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module gsfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        i_rx_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_status,
    input logic [15:0] i_res_conc,
    input logic [15:0] i_res_rng
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status)
            && $stable(i_res_conc) && $stable(i_res_rng))
        else $error("stalled result changed");

    // a new result is traced back to an earlier byte transfer
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready, 2))
        else $error("result without a byte transfer");

    // input never blocks while the output register is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_rx_ready)
        else $error("input stalled with empty output");

endmodule

bind gas_sensor_frame_parser_top gsfp_checker u_gsfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_valid   (i_rx.valid),
    .i_rx_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_conc   (o_res.concentration),
    .i_res_rng    (o_res.full_range)
);

// ===== tb/sv/gas_sensor_frame_parser_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gas_sensor_frame_parser_top_test
// Self-checking bench for the gas sensor frame parser. A short table of
// bytes covers the header, checksum and repeat-reading cases. Random frames
// with noise, broken headers, bad checksums and truncation follow. Every
// accepted byte runs through a local frame predictor, and each result
// transfer is checked in order against the predicted results.
// ----------------------------------------------------------------------------
module gas_sensor_frame_parser_top_test;
    import gsfp_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int FRAME_BYTES  = 750;
    localparam int HOLD_CYCLES  = 300;
    localparam t_result NO_RESULT = '0;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              typed;
        t_result           want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gsfp_byte_if   rx_if ();
    gsfp_result_if res_if ();

    gas_sensor_frame_parser_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] sum_acc;
    logic [WORD_W-1:0] conc_acc;
    logic [WORD_W-1:0] range_acc;
    logic [WORD_W-1:0] last_conc;

    t_result pending_results[$];
    int      fault_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    bit      hold_req = 1'b0;
    bit      quiet_stretch = 1'b0;

    t_row directed_rows [31] = '{
        {8'h00, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'h17, 1'b0, NO_RESULT},
        {8'h04, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'hE9, 1'b1, {1'b1, STATUS_READING, 16'hFFFF, 16'hFFFF}},
        {8'hFF, 1'b0, NO_RESULT},
        {8'h17, 1'b0, NO_RESULT},
        {8'hFF, 1'b1, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'h17, 1'b0, NO_RESULT},
        {8'h04, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'hE7, 1'b1, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'h17, 1'b0, NO_RESULT},
        {8'h04, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'hE4, 1'b1, {1'b1, STATUS_CHECKSUM, 16'h0000, 16'h0000}}
    };

    function automatic t_result frame_result_for_byte(input logic [BYTE_W-1:0] b);
        t_result           r;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] want_ck;
        r = NO_RESULT;
        case (frame_pos)
            POS_GAS, POS_UNIT, POS_DEC: begin
                hdr = (frame_pos == POS_GAS) ? GAS_CODE :
                      (frame_pos == POS_UNIT) ? UNIT_CODE : DECIMALS_CODE;
                if (b != hdr) begin
                    frame_pos = POS_HUNT;
                    return r;
                end
            end
            POS_CONC_HI: conc_acc = {b, 8'h00};
            POS_CONC_LO: conc_acc = conc_acc | {8'h00, b};
            POS_RANGE_HI: range_acc = {b, 8'h00};
            POS_RANGE_LO: range_acc = range_acc | {8'h00, b};
            POS_CHECK: begin
                want_ck = 8'h00 - sum_acc;
                r.concentration = conc_acc;
                r.full_range = range_acc;
                if (want_ck == b) begin
                    if (conc_acc != last_conc) begin
                        r.vld = 1'b1;
                        r.status = STATUS_READING;
                        last_conc = conc_acc;
                    end
                end else begin
                    r.vld = 1'b1;
                    r.status = STATUS_CHECKSUM;
                end
                frame_pos = POS_HUNT;
                return r;
            end
            default: begin
                if (b == START_BYTE) begin
                    sum_acc = '0;
                    frame_pos = POS_GAS;
                end else begin
                    frame_pos = POS_HUNT;
                end
                return r;
            end
        endcase
        sum_acc = sum_acc + b;
        frame_pos = frame_pos + 1'b1;
        return r;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input t_result typed_want);
        t_result r;
        if (!quiet_stretch && $urandom_range(99) < 6) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        r = frame_result_for_byte(b);
        if (typed) r = typed_want;
        if (r.vld) pending_results.push_back(r);
    endtask

    task automatic report_fault(input t_result want, input t_result got);
        fault_count++;
        if (fault_count <= 10) begin
            if (!want.vld)
                $display("unexpected result: status %0d conc %h range %h",
                         got.status, got.concentration, got.full_range);
            else
                $display("mismatch: expected status %0d conc %h range %h, got status %0d conc %h range %h",
                         want.status, want.concentration, want.full_range,
                         got.status, got.concentration, got.full_range);
        end
    endtask

    // result sink with random stalls and one long hold-off
    always @(posedge i_clk) begin : result_sink
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = {1'b1, res_if.status, res_if.concentration, res_if.full_range};
                if (pending_results.size() == 0) begin
                    report_fault(NO_RESULT, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status ||
                        got.concentration !== want.concentration ||
                        got.full_range !== want.full_range)
                        report_fault(want, got);
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= quiet_stretch || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] frame [9];
        logic [BYTE_W-1:0] ck;
        logic [WORD_W-1:0] conc;
        logic [WORD_W-1:0] range_val;
        int                frame_bytes_sent;
        int                frames_done;
        int                nbytes;
        int                sel;

        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        frame_pos = POS_HUNT;
        sum_acc = '0;
        conc_acc = '0;
        range_acc = '0;
        last_conc = '0;
        frame_bytes_sent = 0;
        frames_done = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                      directed_rows[i].want);

        while (frame_bytes_sent < FRAME_BYTES) begin
            quiet_stretch = (frames_done >= 30 && frames_done < 45);
            if (frames_done == 60) hold_req = 1'b1;

            // line noise between frames
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom_range(254)), 1'b0, NO_RESULT);

            sel = $urandom_range(7);
            conc = (sel < 2) ? last_conc : (sel == 2) ? 16'h0000 :
                   (sel == 3) ? 16'hFFFF : 16'($urandom);
            sel = $urandom_range(7);
            range_val = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);

            frame[0] = START_BYTE;
            frame[1] = GAS_CODE;
            frame[2] = UNIT_CODE;
            frame[3] = DECIMALS_CODE;
            frame[4] = conc[15:8];
            frame[5] = conc[7:0];
            frame[6] = range_val[15:8];
            frame[7] = range_val[7:0];
            ck = '0;
            for (int k = 1; k < 8; k++) ck = ck + frame[k];
            frame[8] = 8'h00 - ck;
            if ($urandom_range(6) == 0) frame[8] ^= 8'($urandom_range(255, 1));
            if ($urandom_range(9) == 0) begin
                sel = $urandom_range(3, 1);
                frame[sel] ^= 8'($urandom_range(255, 1));
            end
            nbytes = ($urandom_range(19) == 0) ? $urandom_range(8, 2) : 9;

            for (int k = 0; k < nbytes; k++) send_byte(frame[k], 1'b0, NO_RESULT);
            frame_bytes_sent += nbytes;
            frames_done++;
        end
        quiet_stretch = 1'b0;
        rx_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gsfp_pkg.sv
rtl/gsfp_if.sv
rtl/gsfp_frame_fsm.sv
rtl/gas_sensor_frame_parser_top.sv
rtl/gsfp_checker.sv
tb/sv/gas_sensor_frame_parser_top_test.sv
